// ----- design/scm_pkg.sv -----
// ----------------------------------------------------------------------------
// scm_pkg
// Shared widths, result kinds, register indexes and the pan gain table of
// the stereo channel mixer and meter.
// ----------------------------------------------------------------------------
`default_nettype none

package scm_pkg;

    // Fixed field widths
    localparam int SAMP_W = 24;   // internal sample width, Q1.23
    localparam int VOL_W  = 8;    // channel volume code
    localparam int GAIN_W = 16;   // pan gain, Q1.15 up to 32768
    localparam int MIX_W  = 27;   // mixed output, Q4.23
    localparam int PK_W   = 24;   // channel peak magnitude

    // Result kinds
    localparam logic [1:0] KIND_MIX    = 2'd0;
    localparam logic [1:0] KIND_CHAN   = 2'd1;
    localparam logic [1:0] KIND_MASTER = 2'd2;

    // Configuration register indexes
    localparam logic [2:0] REG_VOLUMES = 3'd0;
    localparam logic [2:0] REG_PANS    = 3'd1;
    localparam logic [2:0] REG_MUTE    = 3'd2;
    localparam logic [2:0] REG_SOLO    = 3'd3;
    localparam logic [2:0] REG_LOADED  = 3'd4;
    localparam logic [2:0] REG_MASTER  = 3'd5;
    localparam logic [2:0] REG_BLOCK   = 3'd6;

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    typedef logic [GAIN_W-1:0] cos_tab_t [0:256];

    // Build cos(m*pi/512) in Q1.15 from a 12-term series in Q30
    function automatic cos_tab_t build_cos_tab();
        cos_tab_t           tab;
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        term;
        logic [63:0]        r;
        logic signed [63:0] acc;
        for (int m = 0; m <= 256; m++) begin
            x    = (64'(m) * PI_Q30 + 64'd256) >> 9;
            x2   = (x * x) >> 30;
            term = 64'd1 << 30;
            acc  = 64'sd1 <<< 30;
            for (int n = 1; n <= 12; n++) begin
                term = ((term * x2) >> 30) / 64'((2 * n - 1) * (2 * n));
                if ((n % 2) == 1)
                    acc = acc - signed'(term);
                else
                    acc = acc + signed'(term);
            end
            if (acc < 0)
                acc = 64'sd0;
            r = (unsigned'(acc) + 64'd16384) >> 15;
            tab[m] = (r > 64'd32768) ? 16'd32768 : r[GAIN_W-1:0];
        end
        return tab;
    endfunction

    localparam cos_tab_t COS_TAB = build_cos_tab();

endpackage

`default_nettype wire

// ----- design/scm_acc_mem.sv -----
// ----------------------------------------------------------------------------
// scm_acc_mem
// Per-channel accumulator store: one synchronous write port, one read port
// with registered data. Entries never written read as zero.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_acc_mem #(
    parameter int DEPTH = 8,
    parameter int AW    = 3,
    parameter int DW    = 162
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          rd_en,
    input  wire logic [AW-1:0] rd_addr,
    output logic      [DW-1:0] rd_data,
    input  wire logic          wr_en,
    input  wire logic [AW-1:0] wr_addr,
    input  wire logic [DW-1:0] wr_data
);

    logic [DW-1:0]    mem [DEPTH];
    logic [DEPTH-1:0] valid_reg;
    logic [DW-1:0]    data_reg;
    logic             rd_valid_reg;

    // Storage array and read register
    always_ff @(posedge clk)
    begin
        if (wr_en)
            mem[wr_addr] <= wr_data;
        if (rd_en)
            data_reg <= mem[rd_addr];
    end

    // Written flags, cleared by reset
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
                valid_reg[wr_addr] <= 1'b1;
            if (rd_en)
                rd_valid_reg <= valid_reg[rd_addr];
        end
    end

    assign rd_data = rd_valid_reg ? data_reg : '0;

endmodule

`default_nettype wire

// ----- design/scm_root.sv -----
// ----------------------------------------------------------------------------
// scm_root
// Bit-serial unit: floor quotient of a sum by the frame count, then the
// floor square root of that quotient, one bit or one root digit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module scm_root #(
    parameter int NW = 63,
    parameter int DW = 11,
    parameter int RW = (NW + 1) / 2
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [NW-1:0] dividend,
    input  wire logic [DW-1:0] divisor,
    output logic               done,
    output logic      [RW-1:0] root
);

    localparam int VW = 2 * RW;
    localparam int CW = $clog2(NW + 1);

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_DIV  = 2'd1;
    localparam logic [1:0] R_SQRT = 2'd2;

    logic [1:0]    state_reg;
    logic [CW-1:0] cnt_reg;
    logic [NW-1:0] q_reg;
    logic [DW:0]   rem_reg;
    logic [DW-1:0] den_reg;
    logic [VW-1:0] v_reg;
    logic [VW-1:0] r_reg;
    logic [VW-1:0] b_reg;

    logic [DW:0]   rem_sh;
    logic          rem_ge;
    logic [DW:0]   rem_next;
    logic [NW-1:0] q_next;
    logic [VW:0]   rb_sum;
    logic          take;

    // Restoring divide step
    always_comb
    begin
        rem_sh   = {rem_reg[DW-1:0], q_reg[NW-1]};
        rem_ge   = rem_sh >= {1'b0, den_reg};
        rem_next = rem_ge ? (rem_sh - {1'b0, den_reg}) : rem_sh;
        q_next   = {q_reg[NW-2:0], rem_ge};
    end

    // Square root digit step
    always_comb
    begin
        rb_sum = {1'b0, r_reg} + {1'b0, b_reg};
        take   = {1'b0, v_reg} >= rb_sum;
    end

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= R_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            case (state_reg)
                R_IDLE:
                begin
                    if (start)
                    begin
                        state_reg <= R_DIV;
                        cnt_reg   <= '0;
                    end
                end
                R_DIV:
                begin
                    if (cnt_reg == CW'(NW - 1))
                    begin
                        state_reg <= R_SQRT;
                        cnt_reg   <= '0;
                    end
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                R_SQRT:
                begin
                    if (cnt_reg == CW'(RW - 1))
                        state_reg <= R_IDLE;
                    else
                        cnt_reg <= cnt_reg + 1'b1;
                end
                default:
                    state_reg <= R_IDLE;
            endcase
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == R_IDLE && start)
        begin
            q_reg   <= dividend;
            den_reg <= divisor;
            rem_reg <= '0;
        end
        else if (state_reg == R_DIV)
        begin
            q_reg   <= q_next;
            rem_reg <= rem_next;
            if (cnt_reg == CW'(NW - 1))
            begin
                v_reg <= VW'(q_next);
                r_reg <= '0;
                b_reg <= VW'(1) << (VW - 2);
            end
        end
        else if (state_reg == R_SQRT)
        begin
            if (take)
            begin
                v_reg <= v_reg - rb_sum[VW-1:0];
                r_reg <= (r_reg >> 1) + b_reg;
            end
            else
                r_reg <= r_reg >> 1;
            b_reg <= b_reg >> 2;
        end
    end

    assign done = (state_reg == R_IDLE);
    assign root = r_reg[RW-1:0];

endmodule

`default_nettype wire

// ----- design/stereo_channel_mixer_meter.sv -----
// Sequence: a channel sample passes S_MUL1, S_MUL2, S_RND, S_SQ and S_ACC
// before the next ready; the last channel of a frame then passes S_MST1
// to S_MST4, and the mixed frame is offered. A new sample is taken only
// after the multiply chain and the read-modify-write of the store are done.
// Block end: each meter runs a bit-serial divide and root (NW = 63 by
// default). Reset restores control and config registers, store reads zero.
// ----------------------------------------------------------------------------
// stereo_channel_mixer_meter
// Eight-channel stereo mixer with constant-power pan, master gain and
// per-block RMS and peak meters.
// ----------------------------------------------------------------------------
`default_nettype none

module stereo_channel_mixer_meter #(
    parameter int NUM_CHANNELS = 8,
    parameter int MAX_BLOCK    = 1024,
    parameter int SAMPLE_BITS  = 24
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // Configuration writes
    input  wire logic                          cfg_valid,
    output logic                               cfg_ready,
    input  wire logic [2:0]                    cfg_index,
    input  wire logic [63:0]                   cfg_data,
    // Sample input
    input  wire logic                          in_valid,
    output logic                               in_ready,
    input  wire logic [2:0]                    channel,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_left,
    input  wire logic signed [SAMPLE_BITS-1:0] sample_right,
    input  wire logic                          in_range,
    // Results
    output logic                               out_valid,
    input  wire logic                          out_ready,
    output logic [1:0]                         kind,
    output logic [2:0]                         meter_channel,
    output logic signed [26:0]                 mix_left,
    output logic signed [26:0]                 mix_right,
    output logic [26:0]                        rms_left,
    output logic [26:0]                        rms_right,
    output logic [26:0]                        peak_left,
    output logic [26:0]                        peak_right,
    output logic                               last
);

    localparam int SW    = scm_pkg::SAMP_W;
    localparam int PW    = scm_pkg::PK_W;
    localparam int XW    = scm_pkg::MIX_W;
    localparam int CSQ_W = 47 + $clog2(MAX_BLOCK);
    localparam int MSQ_W = 53 + $clog2(MAX_BLOCK);
    localparam int FC_W  = $clog2(MAX_BLOCK + 1);
    localparam int MI_W  = $clog2(NUM_CHANNELS + 1);
    localparam int AW    = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int MW    = 2 * CSQ_W + 2 * PW;
    localparam int RW    = (MSQ_W + 1) / 2;
    localparam logic [7:0] CH_MASK = 8'((9'd1 << NUM_CHANNELS) - 9'd1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL1  = 4'd1;
    localparam logic [3:0] S_MUL2  = 4'd2;
    localparam logic [3:0] S_RND   = 4'd3;
    localparam logic [3:0] S_SQ    = 4'd4;
    localparam logic [3:0] S_ACC   = 4'd5;
    localparam logic [3:0] S_MST1  = 4'd6;
    localparam logic [3:0] S_MST2  = 4'd7;
    localparam logic [3:0] S_MST3  = 4'd8;
    localparam logic [3:0] S_MST4  = 4'd9;
    localparam logic [3:0] S_OUT   = 4'd10;
    localparam logic [3:0] S_MRD   = 4'd11;
    localparam logic [3:0] S_MWAIT = 4'd12;
    localparam logic [3:0] S_MCALC = 4'd13;

    // Configuration registers
    logic [63:0] vol_reg;
    logic [63:0] pan_reg;
    logic [7:0]  mute_reg;
    logic [7:0]  solo_reg;
    logic [7:0]  loaded_reg;
    logic [8:0]  mvol_reg;
    logic [10:0] bf_reg;

    // Control
    logic [3:0]      state_reg;
    logic [FC_W-1:0] fc_reg;
    logic [FC_W-1:0] n_reg;
    logic [MI_W-1:0] mi_reg;
    logic            master_sel_reg;

    // Item datapath
    logic [2:0]            ch_reg;
    logic signed [SW-1:0]  sl_reg;
    logic signed [SW-1:0]  sr_reg;
    logic                  aud_reg;
    logic signed [32:0]    p1l_reg;
    logic signed [32:0]    p1r_reg;
    logic [15:0]           gl_reg;
    logic [15:0]           gr_reg;
    logic signed [49:0]    p2l_reg;
    logic signed [49:0]    p2r_reg;
    logic signed [SW-1:0]  ol_reg;
    logic signed [SW-1:0]  or_reg;
    logic [PW-1:0]         al_reg;
    logic [PW-1:0]         ar_reg;
    logic [47:0]           sql_reg;
    logic [47:0]           sqr_reg;

    // Frame and master state
    logic signed [XW-1:0]  fml_reg;
    logic signed [XW-1:0]  fmr_reg;
    logic signed [36:0]    mpl_reg;
    logic signed [36:0]    mpr_reg;
    logic signed [XW-1:0]  mol_reg;
    logic signed [XW-1:0]  mor_reg;
    logic [XW-1:0]         mal_reg;
    logic [XW-1:0]         mar_reg;
    logic [53:0]           msql_reg;
    logic [53:0]           msqr_reg;
    logic [MSQ_W-1:0]      msuml_reg;
    logic [MSQ_W-1:0]      msumr_reg;
    logic [XW-1:0]         mpkl_reg;
    logic [XW-1:0]         mpkr_reg;
    logic [XW-1:0]         hpkl_reg;
    logic [XW-1:0]         hpkr_reg;

    // Result register
    logic                  out_valid_reg;
    logic [1:0]            kind_reg;
    logic [2:0]            mch_reg;
    logic signed [XW-1:0]  mixl_reg;
    logic signed [XW-1:0]  mixr_reg;
    logic [XW-1:0]         rmsl_reg;
    logic [XW-1:0]         rmsr_reg;
    logic [XW-1:0]         pkl_reg;
    logic [XW-1:0]         pkr_reg;
    logic                  last_reg;

    // Store and root unit hookup
    logic                  mem_rd_en;
    logic [AW-1:0]         mem_rd_addr;
    logic [MW-1:0]         mem_rd_data;
    logic                  mem_wr_en;
    logic [AW-1:0]         mem_wr_addr;
    logic [MW-1:0]         mem_wr_data;
    logic                  root_start;
    logic [MSQ_W-1:0]      root_num_l;
    logic [MSQ_W-1:0]      root_num_r;
    logic                  root_done_l;
    logic                  root_done_r;
    logic [RW-1:0]         root_l;
    logic [RW-1:0]         root_r;

    // Combinational helpers
    logic                  in_xfer;
    logic                  ch_ok;
    logic                  has_solo;
    logic [7:0]            vol_sel;
    logic [7:0]            k_sel;
    logic [8:0]            mv_sat;
    logic signed [49:0]    rnd_l;
    logic signed [49:0]    rnd_r;
    logic signed [SW-1:0]  o_l;
    logic signed [SW-1:0]  o_r;
    logic signed [36:0]    mrnd_l;
    logic signed [36:0]    mrnd_r;
    logic signed [XW-1:0]  mo_l;
    logic signed [XW-1:0]  mo_r;
    logic [CSQ_W-1:0]      rd_suml;
    logic [CSQ_W-1:0]      rd_sumr;
    logic [PW-1:0]         rd_pkl;
    logic [PW-1:0]         rd_pkr;
    logic [FC_W-1:0]       n_next;
    logic [FC_W-1:0]       limit;

    assign in_xfer  = in_valid && in_ready;
    assign in_ready = (state_reg == S_IDLE);
    assign cfg_ready = 1'b1;
    assign ch_ok    = 32'(channel) < NUM_CHANNELS;
    assign has_solo = |(solo_reg & loaded_reg & CH_MASK);
    assign vol_sel  = vol_reg[8 * ch_reg +: 8];
    assign k_sel    = pan_reg[8 * ch_reg +: 8] ^ 8'h80;
    assign mv_sat   = (mvol_reg > 9'd256) ? 9'd256 : mvol_reg;

    // Round half up after the gain products
    always_comb
    begin
        rnd_l  = p2l_reg + 50'sd4194304;
        rnd_r  = p2r_reg + 50'sd4194304;
        o_l    = signed'(rnd_l[46:23]);
        o_r    = signed'(rnd_r[46:23]);
        mrnd_l = mpl_reg + 37'sd128;
        mrnd_r = mpr_reg + 37'sd128;
        mo_l   = signed'(mrnd_l[34:8]);
        mo_r   = signed'(mrnd_r[34:8]);
    end

    // Unpack the store entry
    always_comb
    begin
        rd_suml = mem_rd_data[MW-1 -: CSQ_W];
        rd_sumr = mem_rd_data[MW-CSQ_W-1 -: CSQ_W];
        rd_pkl  = mem_rd_data[2*PW-1 -: PW];
        rd_pkr  = mem_rd_data[PW-1:0];
    end

    // Block length limit and next frame count
    always_comb
    begin
        n_next = fc_reg + 1'b1;
        if (bf_reg == 11'd0)
            limit = FC_W'(1);
        else if (32'(bf_reg) > MAX_BLOCK)
            limit = FC_W'(MAX_BLOCK);
        else
            limit = FC_W'(bf_reg);
    end

    // Store port control
    always_comb
    begin
        mem_rd_en   = 1'b0;
        mem_rd_addr = channel[AW-1:0];
        mem_wr_en   = 1'b0;
        mem_wr_addr = ch_reg[AW-1:0];
        mem_wr_data = {rd_suml + CSQ_W'(sql_reg), rd_sumr + CSQ_W'(sqr_reg),
                       (al_reg > rd_pkl) ? al_reg : rd_pkl,
                       (ar_reg > rd_pkr) ? ar_reg : rd_pkr};
        root_start  = 1'b0;
        root_num_l  = msuml_reg;
        root_num_r  = msumr_reg;
        case (state_reg)
            S_IDLE:
                mem_rd_en = in_xfer && ch_ok;
            S_ACC:
                mem_wr_en = 1'b1;
            S_MRD:
            begin
                mem_rd_addr = mi_reg[AW-1:0];
                mem_rd_en   = (mi_reg != MI_W'(NUM_CHANNELS));
                root_start  = (mi_reg == MI_W'(NUM_CHANNELS));
            end
            S_MWAIT:
            begin
                mem_wr_en   = 1'b1;
                mem_wr_addr = mi_reg[AW-1:0];
                mem_wr_data = '0;
                root_start  = 1'b1;
                root_num_l  = MSQ_W'(rd_suml);
                root_num_r  = MSQ_W'(rd_sumr);
            end
            default:
            begin
                mem_rd_en = 1'b0;
            end
        endcase
    end

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vol_reg    <= 64'hC0C0C0C0C0C0C0C0;
            pan_reg    <= '0;
            mute_reg   <= '0;
            solo_reg   <= '0;
            loaded_reg <= '0;
            mvol_reg   <= 9'd256;
            bf_reg     <= 11'd256;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (cfg_index)
                scm_pkg::REG_VOLUMES: vol_reg    <= cfg_data;
                scm_pkg::REG_PANS:    pan_reg    <= cfg_data;
                scm_pkg::REG_MUTE:    mute_reg   <= cfg_data[7:0];
                scm_pkg::REG_SOLO:    solo_reg   <= cfg_data[7:0];
                scm_pkg::REG_LOADED:  loaded_reg <= cfg_data[7:0];
                scm_pkg::REG_MASTER:  mvol_reg   <= cfg_data[8:0];
                scm_pkg::REG_BLOCK:   bf_reg     <= cfg_data[10:0];
                default:              ;
            endcase
        end
    end

    // Sequencer and control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            fc_reg         <= '0;
            mi_reg         <= '0;
            master_sel_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
            fml_reg        <= '0;
            fmr_reg        <= '0;
            msuml_reg      <= '0;
            msumr_reg      <= '0;
            mpkl_reg       <= '0;
            mpkr_reg       <= '0;
        end
        else
        begin
            case (state_reg)
                S_IDLE:
                begin
                    if (in_xfer && ch_ok)
                        state_reg <= S_MUL1;
                end
                S_MUL1:  state_reg <= S_MUL2;
                S_MUL2:  state_reg <= S_RND;
                S_RND:   state_reg <= S_SQ;
                S_SQ:    state_reg <= S_ACC;
                S_ACC:
                begin
                    // Accumulate audible channels into the frame
                    if (aud_reg)
                    begin
                        fml_reg <= fml_reg + XW'(ol_reg);
                        fmr_reg <= fmr_reg + XW'(or_reg);
                    end
                    if (ch_reg == 3'(NUM_CHANNELS - 1))
                        state_reg <= S_MST1;
                    else
                        state_reg <= S_IDLE;
                end
                S_MST1:
                begin
                    fml_reg   <= '0;
                    fmr_reg   <= '0;
                    state_reg <= S_MST2;
                end
                S_MST2:  state_reg <= S_MST3;
                S_MST3:
                begin
                    if (mal_reg > mpkl_reg)
                        mpkl_reg <= mal_reg;
                    if (mar_reg > mpkr_reg)
                        mpkr_reg <= mar_reg;
                    state_reg <= S_MST4;
                end
                S_MST4:
                begin
                    msuml_reg     <= msuml_reg + MSQ_W'(msql_reg);
                    msumr_reg     <= msumr_reg + MSQ_W'(msqr_reg);
                    mi_reg        <= '0;
                    out_valid_reg <= 1'b1;
                    if (n_next < limit)
                        fc_reg <= n_next;
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    // Hold the result until its transfer
                    if (out_ready)
                    begin
                        out_valid_reg <= 1'b0;
                        state_reg     <= last_reg ? S_IDLE : S_MRD;
                    end
                end
                S_MRD:
                begin
                    if (mi_reg == MI_W'(NUM_CHANNELS))
                    begin
                        // Master meter: drop the master accumulators
                        master_sel_reg <= 1'b1;
                        msuml_reg      <= '0;
                        msumr_reg      <= '0;
                        mpkl_reg       <= '0;
                        mpkr_reg       <= '0;
                        fc_reg         <= '0;
                        state_reg      <= S_MCALC;
                    end
                    else
                    begin
                        master_sel_reg <= 1'b0;
                        state_reg      <= S_MWAIT;
                    end
                end
                S_MWAIT: state_reg <= S_MCALC;
                S_MCALC:
                begin
                    if (root_done_l && root_done_r)
                    begin
                        out_valid_reg <= 1'b1;
                        if (!master_sel_reg)
                            mi_reg <= mi_reg + 1'b1;
                        state_reg <= S_OUT;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    // Item and meter datapath
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && in_xfer)
        begin
            ch_reg <= channel;
            if (loaded_reg[channel] && in_range)
            begin
                sl_reg <= SW'(sample_left);
                sr_reg <= SW'(sample_right);
            end
            else
            begin
                sl_reg <= '0;
                sr_reg <= '0;
            end
            aud_reg <= loaded_reg[channel] && !mute_reg[channel]
                       && (!has_solo || solo_reg[channel]);
        end
        if (state_reg == S_MUL1)
        begin
            p1l_reg <= sl_reg * signed'({1'b0, vol_sel});
            p1r_reg <= sr_reg * signed'({1'b0, vol_sel});
            gl_reg  <= scm_pkg::COS_TAB[{1'b0, k_sel}];
            gr_reg  <= scm_pkg::COS_TAB[9'd256 - {1'b0, k_sel}];
        end
        if (state_reg == S_MUL2)
        begin
            p2l_reg <= p1l_reg * signed'({1'b0, gl_reg});
            p2r_reg <= p1r_reg * signed'({1'b0, gr_reg});
        end
        if (state_reg == S_RND)
        begin
            ol_reg <= o_l;
            or_reg <= o_r;
            al_reg <= o_l[SW-1] ? PW'(-o_l) : PW'(o_l);
            ar_reg <= o_r[SW-1] ? PW'(-o_r) : PW'(o_r);
        end
        if (state_reg == S_SQ)
        begin
            sql_reg <= al_reg * al_reg;
            sqr_reg <= ar_reg * ar_reg;
        end
        if (state_reg == S_MST1)
        begin
            mpl_reg <= fml_reg * signed'({1'b0, mv_sat});
            mpr_reg <= fmr_reg * signed'({1'b0, mv_sat});
        end
        if (state_reg == S_MST2)
        begin
            mol_reg <= mo_l;
            mor_reg <= mo_r;
            mal_reg <= mo_l[XW-1] ? XW'(-mo_l) : XW'(mo_l);
            mar_reg <= mo_r[XW-1] ? XW'(-mo_r) : XW'(mo_r);
        end
        if (state_reg == S_MST3)
        begin
            msql_reg <= mal_reg * mal_reg;
            msqr_reg <= mar_reg * mar_reg;
        end
        if (state_reg == S_MST4)
        begin
            n_reg    <= n_next;
            kind_reg <= scm_pkg::KIND_MIX;
            mch_reg  <= '0;
            mixl_reg <= mol_reg;
            mixr_reg <= mor_reg;
            rmsl_reg <= '0;
            rmsr_reg <= '0;
            pkl_reg  <= '0;
            pkr_reg  <= '0;
            last_reg <= (n_next < limit);
        end
        // Capture the peaks that go with the meter being computed
        if (state_reg == S_MRD && mi_reg == MI_W'(NUM_CHANNELS))
        begin
            hpkl_reg <= mpkl_reg;
            hpkr_reg <= mpkr_reg;
        end
        if (state_reg == S_MWAIT)
        begin
            hpkl_reg <= XW'(rd_pkl);
            hpkr_reg <= XW'(rd_pkr);
        end
        if (state_reg == S_MCALC && root_done_l && root_done_r)
        begin
            kind_reg <= master_sel_reg ? scm_pkg::KIND_MASTER : scm_pkg::KIND_CHAN;
            mch_reg  <= master_sel_reg ? 3'd0 : 3'(mi_reg);
            mixl_reg <= '0;
            mixr_reg <= '0;
            rmsl_reg <= XW'(root_l);
            rmsr_reg <= XW'(root_r);
            pkl_reg  <= hpkl_reg;
            pkr_reg  <= hpkr_reg;
            last_reg <= master_sel_reg;
        end
    end

    scm_acc_mem #(
        .DEPTH (NUM_CHANNELS),
        .AW    (AW),
        .DW    (MW)
    ) u_acc_mem (
        .clk     (clk),
        .rst_n   (rst_n),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data)
    );

    scm_root #(
        .NW (MSQ_W),
        .DW (FC_W),
        .RW (RW)
    ) u_root_left (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (root_num_l),
        .divisor  (n_reg),
        .done     (root_done_l),
        .root     (root_l)
    );

    scm_root #(
        .NW (MSQ_W),
        .DW (FC_W),
        .RW (RW)
    ) u_root_right (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (root_start),
        .dividend (root_num_r),
        .divisor  (n_reg),
        .done     (root_done_r),
        .root     (root_r)
    );

    assign out_valid     = out_valid_reg;
    assign kind          = kind_reg;
    assign meter_channel = mch_reg;
    assign mix_left      = mixl_reg;
    assign mix_right     = mixr_reg;
    assign rms_left      = rmsl_reg;
    assign rms_right     = rmsr_reg;
    assign peak_left     = pkl_reg;
    assign peak_right    = pkr_reg;
    assign last          = last_reg;

    // Checks
    a_chan_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == scm_pkg::KIND_CHAN) |-> !last)
        else $error("channel meter marked last");

    a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
        in_ready |-> !out_valid)
        else $error("input taken while a result is pending");

    a_block_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && kind == scm_pkg::KIND_MASTER) |-> fc_reg == '0)
        else $error("frame count not cleared at block end");

    a_meter_index: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && kind == scm_pkg::KIND_CHAN) |-> 32'(meter_channel) < NUM_CHANNELS)
        else $error("meter channel out of range");

    a_roots_in_step: assert property (@(posedge clk) disable iff (!rst_n)
        root_done_l == root_done_r)
        else $error("root units out of step");

endmodule

`default_nettype wire
